// File: sv/ejs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the pair conversion for the EUC-JP to Shift_JIS stream block.
// No dependencies; every other file of the block refers to this package by scoped names.
package ejs_pkg;

	// Configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic REG_DEFAULT_PAIR = 1'b0;
	localparam logic REG_OUT_CAPACITY = 1'b1;
	localparam logic [15:0] DEFAULT_PAIR_RST = 16'h8140;
	localparam logic [15:0] OUT_CAPACITY_RST = 16'd4096;

	// Result queue
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_AW = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_CW = RQ_AW + 1;

	// Result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_OVF = 2'd2;

	// Byte codes
	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_SS2 = 8'h8e;
	localparam logic [7:0] BYTE_SS3 = 8'h8f;
	localparam logic [7:0] LEAD_LO = 8'ha1;
	localparam logic [7:0] LEAD_HI = 8'hfe;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TRAIL   = 3'd1,
		PH_SS2     = 3'd2,
		PH_SS3A    = 3'd3,
		PH_SS3B    = 3'd4,
		PH_DISCARD = 3'd5
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic        substituted;
		logic [15:0] out_count;
		logic [15:0] default_count;
		logic        last;
	} res_t;

	// JIS row/cell to Shift_JIS pair, high byte in [15:8]
	function automatic logic [15:0] convert_pair(input logic [7:0] lead, input logic [7:0] trail);
		logic [6:0] row;
		logic [6:0] col;
		logic [7:0] nh;
		logic [7:0] nl;
		row  = lead[6:0];
		col  = trail[6:0];
		nh   = 8'(({1'b0, row} - 8'h21) >> 1) + 8'h81;
		if (nh > 8'h9f) begin
			nh = nh + 8'h40;
		end
		if (row[0]) begin
			nl = {1'b0, col} + 8'h1f;
			if (col > 7'h5f) begin
				nl = nl + 8'h01;
			end
		end else begin
			nl = {1'b0, col} + 8'h7e;
		end
		return {nh, nl};
	endfunction

endpackage

// File: sv/ejs_conv.sv
`timescale 1ns / 1ps
// Per-byte conversion step: sequence state registers and the logic that turns one byte
// into up to two results. Depends on ejs_pkg.
module ejs_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          data_b,
	input  logic [15:0]         default_pair,
	input  logic [15:0]         out_capacity,
	output logic [1:0]          nres,
	output ejs_pkg::res_t       res0,
	output ejs_pkg::res_t       res1
);

	ejs_pkg::phase_t phase_q, phase_d;
	logic [7:0]  lead_q, lead_d;
	logic [15:0] wcnt_q, wcnt_d;
	logic [15:0] scnt_q, scnt_d;
	logic        ovf_q, ovf_d;

	logic        fits;
	logic [15:0] pair;
	logic [15:0] wc1;
	logic [15:0] wc2;
	logic [15:0] sc1;

	assign fits = ({1'b0, wcnt_q} + 17'd2) <= {1'b0, out_capacity};
	assign pair = ejs_pkg::convert_pair(lead_q, data_b);
	assign wc1  = wcnt_q + 16'd1;
	assign wc2  = wcnt_q + 16'd2;
	assign sc1  = scnt_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		lead_d  = lead_q;
		wcnt_d  = wcnt_q;
		scnt_d  = scnt_q;
		ovf_d   = ovf_q;
		nres    = 2'd0;
		res0    = '0;
		res1    = '0;
		if (data_b == ejs_pkg::BYTE_NUL) begin
			// end of string: report and clear everything
			res0.kind          = ovf_q ? ejs_pkg::KIND_OVF : ejs_pkg::KIND_END;
			res0.out_count     = wcnt_q;
			res0.default_count = scnt_q;
			res0.last          = 1'b1;
			nres    = 2'd1;
			phase_d = ejs_pkg::PH_IDLE;
			lead_d  = '0;
			wcnt_d  = '0;
			scnt_d  = '0;
			ovf_d   = 1'b0;
		end else begin
			unique case (phase_q)
				ejs_pkg::PH_IDLE: begin
					if (wcnt_q >= out_capacity) begin
						phase_d = ejs_pkg::PH_DISCARD;
					end else if (data_b >= ejs_pkg::LEAD_LO && data_b <= ejs_pkg::LEAD_HI) begin
						lead_d  = data_b;
						phase_d = ejs_pkg::PH_TRAIL;
					end else if (data_b == ejs_pkg::BYTE_SS3) begin
						if (fits) begin
							phase_d = ejs_pkg::PH_SS3A;
						end else begin
							ovf_d   = 1'b1;
							phase_d = ejs_pkg::PH_DISCARD;
						end
					end else if (data_b == ejs_pkg::BYTE_SS2) begin
						phase_d = ejs_pkg::PH_SS2;
					end else begin
						res0.out_byte      = data_b;
						res0.out_count     = wc1;
						res0.default_count = scnt_q;
						res0.last          = 1'b1;
						nres   = 2'd1;
						wcnt_d = wc1;
					end
				end
				ejs_pkg::PH_TRAIL: begin
					if (fits) begin
						res0.out_byte      = pair[15:8];
						res0.out_count     = wc1;
						res0.default_count = scnt_q;
						res1.out_byte      = pair[7:0];
						res1.out_count     = wc2;
						res1.default_count = scnt_q;
						res1.last          = 1'b1;
						nres    = 2'd2;
						wcnt_d  = wc2;
						lead_d  = '0;
						phase_d = ejs_pkg::PH_IDLE;
					end else begin
						ovf_d   = 1'b1;
						phase_d = ejs_pkg::PH_DISCARD;
					end
				end
				ejs_pkg::PH_SS2: begin
					res0.out_byte      = data_b;
					res0.out_count     = wc1;
					res0.default_count = scnt_q;
					res0.last          = 1'b1;
					nres    = 2'd1;
					wcnt_d  = wc1;
					phase_d = ejs_pkg::PH_IDLE;
				end
				ejs_pkg::PH_SS3A: begin
					phase_d = ejs_pkg::PH_SS3B;
				end
				ejs_pkg::PH_SS3B: begin
					if (fits) begin
						res0.out_byte      = default_pair[15:8];
						res0.substituted   = 1'b1;
						res0.out_count     = wc1;
						res0.default_count = sc1;
						res1.out_byte      = default_pair[7:0];
						res1.substituted   = 1'b1;
						res1.out_count     = wc2;
						res1.default_count = sc1;
						res1.last          = 1'b1;
						nres    = 2'd2;
						wcnt_d  = wc2;
						scnt_d  = sc1;
						phase_d = ejs_pkg::PH_IDLE;
					end else begin
						ovf_d   = 1'b1;
						phase_d = ejs_pkg::PH_DISCARD;
					end
				end
				default: begin
					phase_d = ejs_pkg::PH_DISCARD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ejs_pkg::PH_IDLE;
			lead_q  <= '0;
			wcnt_q  <= '0;
			scnt_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			lead_q  <= lead_d;
			wcnt_q  <= wcnt_d;
			scnt_q  <= scnt_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

// File: sv/ejs_rfifo.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two results per cycle, hands out one per cycle when popped.
// Depends on ejs_pkg.
module ejs_rfifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    npush,
	input  ejs_pkg::res_t wdata0,
	input  ejs_pkg::res_t wdata1,
	input  logic          pop,
	output logic          nonempty,
	output logic          room2,
	output ejs_pkg::res_t head
);

	ejs_pkg::res_t mem_q [ejs_pkg::RQ_DEPTH];
	logic [ejs_pkg::RQ_AW-1:0] wr_q;
	logic [ejs_pkg::RQ_AW-1:0] rd_q;
	logic [ejs_pkg::RQ_CW-1:0] cnt_q;
	logic [ejs_pkg::RQ_AW-1:0] wr1;

	assign wr1      = wr_q + ejs_pkg::RQ_AW'(1);
	assign nonempty = cnt_q != '0;
	assign room2    = cnt_q <= ejs_pkg::RQ_CW'(ejs_pkg::RQ_DEPTH - 2);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (npush != 2'd0) begin
			mem_q[wr_q] <= wdata0;
		end
		if (npush == 2'd2) begin
			mem_q[wr1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ejs_pkg::RQ_AW'(npush);
			rd_q  <= rd_q + ejs_pkg::RQ_AW'(pop);
			cnt_q <= cnt_q + ejs_pkg::RQ_CW'(npush) - ejs_pkg::RQ_CW'(pop);
		end
	end

endmodule

// File: sv/euc_jp_to_sjis_stream_top.sv
`timescale 1ns / 1ps
// EUC-JP to Shift_JIS stream converter, top level: input register, configuration
// registers, conversion step and result queue. Depends on ejs_pkg, ejs_conv, ejs_rfifo.
//
// Feed EUC-JP bytes of NUL-terminated strings on in_byte; each accepted byte yields zero,
// one or two result items (data bytes, or one end record for the NUL). A byte is taken into
// an input register and converted from there into a four-entry result queue once two slots
// are free; results leave at one item per cycle while res_stall is low, so bytes that give
// zero or one result flow at one byte per cycle, and a converted pair or an SS3 substitute
// yields two output items. The output port bounds the sustained rate: one result item per
// clock. Write default_pair (offset 0x0) and out_capacity (offset 0x4) only while no string
// is in flight; pready is always high.
module euc_jp_to_sjis_stream_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   in_byte,
	// result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [1:0]                   kind,
	output logic [7:0]                   out_byte,
	output logic                         substituted,
	output logic [15:0]                  out_count,
	output logic [15:0]                  default_count,
	output logic                         last,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ejs_pkg::ADDR_W-1:0]   paddr,
	input  logic [ejs_pkg::DATA_W-1:0]   pwdata,
	output logic [ejs_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	logic [15:0]   default_pair_q;
	logic [15:0]   out_capacity_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          room2;
	logic          step_en;
	logic [1:0]    nres;
	logic [1:0]    npush;
	ejs_pkg::res_t res0;
	ejs_pkg::res_t res1;
	ejs_pkg::res_t head;
	logic          pop;

	// configuration registers; the register index is the word address bit
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_pair_q <= ejs_pkg::DEFAULT_PAIR_RST;
			out_capacity_q <= ejs_pkg::OUT_CAPACITY_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				ejs_pkg::REG_DEFAULT_PAIR: default_pair_q <= pwdata[15:0];
				ejs_pkg::REG_OUT_CAPACITY: out_capacity_q <= pwdata[15:0];
				default:                   default_pair_q <= default_pair_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ejs_pkg::REG_DEFAULT_PAIR: prdata = {16'd0, default_pair_q};
			ejs_pkg::REG_OUT_CAPACITY: prdata = {16'd0, out_capacity_q};
			default:                   prdata = '0;
		endcase
	end

	// input register: advance the held item into the queue only when two slots are free
	assign step_en  = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	ejs_conv u_conv (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.data_b       (byte_s1),
		.default_pair (default_pair_q),
		.out_capacity (out_capacity_q),
		.nres         (nres),
		.res0         (res0),
		.res1         (res1)
	);

	// drop results when the step is not taken
	assign npush = step_en ? nres : 2'd0;
	assign pop   = res_valid && !res_stall;

	ejs_rfifo u_rfifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.npush    (npush),
		.wdata0   (res0),
		.wdata1   (res1),
		.pop      (pop),
		.nonempty (res_valid),
		.room2    (room2),
		.head     (head)
	);

	assign kind          = head.kind;
	assign out_byte      = head.out_byte;
	assign substituted   = head.substituted;
	assign out_count     = head.out_count;
	assign default_count = head.default_count;
	assign last          = head.last;

endmodule

// File: sv/ejs_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the EUC-JP to Shift_JIS stream block, bound to the top level.
// Depends on ejs_pkg and euc_jp_to_sjis_stream_top.
module ejs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  kind,
	input logic [7:0]  out_byte,
	input logic        substituted,
	input logic [15:0] out_count,
	input logic        last,
	input logic        pready
);

	// a stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(out_byte)
			&& $stable(out_count) && $stable(last))
		else $error("stalled result item changed");

	// end records carry no byte and close the item
	a_end_rec: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != ejs_pkg::KIND_DATA |-> last && out_byte == 8'd0 && !substituted)
		else $error("malformed end record");

	// only data items are substitutes, and they count at least one byte
	a_sub_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && substituted |-> kind == ejs_pkg::KIND_DATA && out_count != 16'd0)
		else $error("substitute flag on non-data item");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind euc_jp_to_sjis_stream_top ejs_chk u_ejs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.kind        (kind),
	.out_byte    (out_byte),
	.substituted (substituted),
	.out_count   (out_count),
	.last        (last),
	.pready      (pready)
);
